// File: sv/scp_pkg.sv
// Shared types, sizes and codes for the smoothed conditional probability counter.
package scp_pkg;

  localparam int MAX_DOMAIN     = 16;
  localparam int PARENT_CONFIGS = 256;
  localparam int COUNT_BITS     = 32;

  localparam int JOINT_DEPTH = MAX_DOMAIN * PARENT_CONFIGS;
  localparam int JOINT_AW    = $clog2(JOINT_DEPTH);
  localparam int PARENT_AW   = (PARENT_CONFIGS > 1) ? $clog2(PARENT_CONFIGS) : 1;

  // field widths
  localparam int CHILD_W  = 4;
  localparam int PARENT_W = 8;
  localparam int AMOUNT_W = 16;
  localparam int ALPHA_W  = 16;
  localparam int DOMAIN_W = 5;
  localparam int PROB_W   = 17;

  // alpha is Q8.8, result is Q1.16
  localparam int ALPHA_FRAC = 8;
  localparam int Q_FRAC     = 16;
  localparam int NUM_W      = COUNT_BITS + ALPHA_FRAC + 1;
  localparam int REM_W      = NUM_W + 1;
  localparam int STEP_W     = $clog2(Q_FRAC);

  localparam logic [PROB_W-1:0]   ONE_Q16      = PROB_W'(1) << Q_FRAC;
  localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = ALPHA_W'(256);
  localparam logic [DOMAIN_W-1:0] DOMAIN_RESET = DOMAIN_W'(2);

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN = 1'b1;

  // command codes
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic                command;
    logic [CHILD_W-1:0]  child_value;
    logic [PARENT_W-1:0] parent_config;
    logic [AMOUNT_W-1:0] count_amount;
  } in_item_t;

  typedef struct packed {
    logic [PROB_W-1:0] probability;
    logic              divide_error;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic clr_en;
    logic in_ready;
    logic rd_en;
    logic wr_en;
    logic div_start;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_query;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

// File: sv/scp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module scp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/scp_div.sv
// Iterative restoring divider giving a saturated Q1.16 fraction, one bit per cycle.
module scp_div
  import scp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [NUM_W-1:0]  den_i,
  output logic              done_o,
  output logic [PROB_W-1:0] quot_o,
  output logic              err_o
);

  logic              busy_q, busy_d;
  logic              first_q, first_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [REM_W-1:0]  den_q, den_d;
  logic [PROB_W-1:0] quot_q, quot_d;
  logic              err_q, err_d;
  logic [REM_W-1:0]  shifted;

  assign shifted = rem_q << 1;

  always_comb begin
    busy_d  = busy_q;
    first_d = first_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    den_d   = den_q;
    quot_d  = quot_q;
    err_d   = err_q;
    if (start_i) begin
      busy_d  = 1'b1;
      first_d = 1'b1;
      cnt_d   = '0;
      rem_d   = REM_W'(num_i);
      den_d   = REM_W'(den_i);
      quot_d  = '0;
      err_d   = 1'b0;
    end else if (busy_q) begin
      if (first_q) begin
        // special cases settled before iterating
        first_d = 1'b0;
        if (den_q == '0) begin
          err_d  = 1'b1;
          quot_d = '0;
          busy_d = 1'b0;
          done_d = 1'b1;
        end else if (rem_q >= den_q) begin
          quot_d = ONE_Q16;
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end else begin
        if (shifted >= den_q) begin
          rem_d  = shifted - den_q;
          quot_d = {quot_q[PROB_W-2:0], 1'b1};
        end else begin
          rem_d  = shifted;
          quot_d = {quot_q[PROB_W-2:0], 1'b0};
        end
        cnt_d = cnt_q + STEP_W'(1);
        if (cnt_q == STEP_W'(Q_FRAC - 1)) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      first_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      first_q <= first_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
    err_q  <= err_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign err_o  = err_q;

endmodule

// File: sv/scp_ctrl.sv
// Control state machine: clear sweep, read-modify-write for adds, divide for queries.
module scp_ctrl
  import scp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (status_i.clr_last) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_READ;
      ST_READ:  state_d = ST_EXEC;
      ST_EXEC:  state_d = status_i.is_query ? ST_DIV : ST_IDLE;
      ST_DIV:   if (status_i.div_done) state_d = ST_OUT;
      ST_OUT:   if (status_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clr_en   = 1'b1;
      ST_IDLE:  cmd_o.in_ready = 1'b1;
      ST_READ:  cmd_o.rd_en    = 1'b1;
      ST_EXEC: begin
        cmd_o.wr_en     = !status_i.is_query;
        cmd_o.div_start = status_i.is_query;
      end
      ST_DIV:   cmd_o = '0;
      ST_OUT:   cmd_o.out_load = status_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/scp_datapath.sv
// Datapath: config registers, count memories, saturating update, operand build, output register.
module scp_datapath
  import scp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctrl_cmd_t            cmd_i,
  output dp_status_t           status_o,
  input  logic                 in_valid_i,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ALPHA_W-1:0]   cfg_wdata_i
);

  logic [ALPHA_W-1:0]  alpha_q, alpha_d;
  logic [DOMAIN_W-1:0] domain_q, domain_d;
  in_item_t            item_q;
  logic [JOINT_AW-1:0] clr_q, clr_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_data_q, out_data_d;

  logic                  in_range;
  logic [JOINT_AW-1:0]   joint_addr;
  logic [PARENT_AW-1:0]  tot_addr;
  logic [COUNT_BITS-1:0] joint_rd, tot_rd;
  logic [COUNT_BITS-1:0] joint_wd, tot_wd;
  logic [COUNT_BITS:0]   joint_sum, tot_sum;
  logic                  joint_we, tot_we;
  logic [JOINT_AW-1:0]   joint_waddr;
  logic [PARENT_AW-1:0]  tot_waddr;
  logic [COUNT_BITS-1:0] joint_use, tot_use;
  logic [ALPHA_W+DOMAIN_W-1:0] alpha_dom;
  logic [NUM_W-1:0]      num, den;
  logic                  div_done;
  logic [PROB_W-1:0]     div_quot;
  logic                  div_err;

  // configuration
  always_comb begin
    alpha_d  = alpha_q;
    domain_d = domain_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ALPHA:  alpha_d  = cfg_wdata_i;
        CFG_DOMAIN: domain_d = cfg_wdata_i[DOMAIN_W-1:0];
        default:    alpha_d  = alpha_q;
      endcase
    end
  end

  // addressing of the held item
  assign in_range   = (32'(item_q.child_value) < MAX_DOMAIN) &&
                      (32'(item_q.parent_config) < PARENT_CONFIGS);
  assign joint_addr = JOINT_AW'(32'(item_q.parent_config) * MAX_DOMAIN +
                                32'(item_q.child_value));
  assign tot_addr   = PARENT_AW'(item_q.parent_config);

  // saturating updates
  assign joint_sum = {1'b0, joint_rd} + (COUNT_BITS + 1)'(item_q.count_amount);
  assign tot_sum   = {1'b0, tot_rd} + (COUNT_BITS + 1)'(item_q.count_amount);

  always_comb begin
    if (cmd_i.clr_en) begin
      joint_we    = 1'b1;
      tot_we      = (32'(clr_q) < PARENT_CONFIGS);
      joint_waddr = clr_q;
      tot_waddr   = PARENT_AW'(clr_q);
      joint_wd    = '0;
      tot_wd      = '0;
    end else begin
      joint_we    = cmd_i.wr_en && in_range;
      tot_we      = cmd_i.wr_en && in_range;
      joint_waddr = joint_addr;
      tot_waddr   = tot_addr;
      joint_wd    = joint_sum[COUNT_BITS] ? '1 : joint_sum[COUNT_BITS-1:0];
      tot_wd      = tot_sum[COUNT_BITS] ? '1 : tot_sum[COUNT_BITS-1:0];
    end
  end

  scp_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(JOINT_DEPTH),
    .AW   (JOINT_AW)
  ) u_joint_ram (
    .clk_i  (clk_i),
    .we_i   (joint_we),
    .waddr_i(joint_waddr),
    .wdata_i(joint_wd),
    .re_i   (cmd_i.rd_en),
    .raddr_i(joint_addr),
    .rdata_o(joint_rd)
  );

  scp_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(PARENT_CONFIGS),
    .AW   (PARENT_AW)
  ) u_total_ram (
    .clk_i  (clk_i),
    .we_i   (tot_we),
    .waddr_i(tot_waddr),
    .wdata_i(tot_wd),
    .re_i   (cmd_i.rd_en),
    .raddr_i(tot_addr),
    .rdata_o(tot_rd)
  );

  // operands in Q8.8 units; out-of-range items count as zero
  assign joint_use = in_range ? joint_rd : '0;
  assign tot_use   = in_range ? tot_rd : '0;
  assign alpha_dom = (ALPHA_W + DOMAIN_W)'(alpha_q) * (ALPHA_W + DOMAIN_W)'(domain_q);
  assign num = (NUM_W'(joint_use) << ALPHA_FRAC) + NUM_W'(alpha_q);
  assign den = (NUM_W'(tot_use) << ALPHA_FRAC) + NUM_W'(alpha_dom);

  scp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (num),
    .den_i  (den),
    .done_o (div_done),
    .quot_o (div_quot),
    .err_o  (div_err)
  );

  assign clr_d = cmd_i.clr_en ? clr_q + JOINT_AW'(1) : clr_q;

  // output beat register
  always_comb begin
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.out_load) begin
      out_valid_d              = 1'b1;
      out_data_d.probability   = div_quot;
      out_data_d.divide_error  = div_err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q     <= ALPHA_RESET;
      domain_q    <= DOMAIN_RESET;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      alpha_q     <= alpha_d;
      domain_q    <= domain_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (in_valid_i && cmd_i.in_ready) begin
      item_q <= in_data_i;
    end
  end

  assign status_o.clr_last = (clr_q == JOINT_AW'(JOINT_DEPTH - 1));
  assign status_o.is_query = (item_q.command == CMD_QUERY);
  assign status_o.div_done = div_done;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: sv/smoothed_cond_prob_counter_unit.sv
// Top level of the smoothed conditional probability counter.
//
//   channel  dir  handshake                  payload
//   in       in   in_valid_i / in_ready_o    in_data_i  (in_item_t)
//   out      out  out_valid_o / out_ready_i  out_data_o (out_item_t)
//   cfg      in   cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// After reset both count memories are swept to zero, one entry a cycle, with
// in_ready_o low for all JOINT_DEPTH (4096) entries; config writes are taken meanwhile.
// An add beat goes through accept, memory read and saturating write back. A query
// beat goes through accept, read, operand build, a check step, 16 divider steps, done
// handoff and output load, skipping the divider steps when the denominator is zero or
// the quotient hits one. The output load waits until the output register frees.
module smoothed_cond_prob_counter_unit
  import scp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ALPHA_W-1:0]   cfg_wdata_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  scp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  scp_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  assign in_ready_o = cmd.in_ready;

endmodule
